// ===== rtl/ray_triangle_intersect_macros.svh =====
// Assertion macros shared by the ray/triangle checker.
// No dependencies; take in with `include before use.
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RTI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RTI_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/rti_pkg.sv =====
// Shared widths, codes, types and helpers for the ray/triangle intersect block.
// No dependencies; all other files refer to it by scoped names.
`default_nettype none

package rti_pkg;

   // field and port widths
   localparam int COORD_W    = 32;
   localparam int EXT_W      = COORD_W + 1;
   localparam int FRAC_BITS  = 16;
   localparam int WIDE_W     = 102;
   localparam int LIMB_W     = 34;
   localparam int MUL_B_W    = LIMB_W;
   localparam int PROD_W     = 4 * LIMB_W;
   localparam int DIV_BITS   = 34;
   localparam int T_W        = COORD_W - 1;
   localparam int BARY_W     = FRAC_BITS + 1;
   localparam int PIPE_DEPTH = 11 + DIV_BITS;

   localparam int REQ_DATA_W = 6 * COORD_W;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 168;
   localparam int RSP_USER_W = 1;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TEST = 1'b1;

   // vertex select codes
   localparam logic [1:0] VSEL_A    = 2'd0;
   localparam logic [1:0] VSEL_B    = 2'd1;
   localparam logic [1:0] VSEL_C    = 2'd2;
   localparam logic [1:0] VSEL_NONE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DET_EPS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_T_MIN   = 1'b1;

   localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [EXT_W-1:0]   ext_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic signed [MUL_B_W-1:0] mulb_type;
   typedef logic signed [PROD_W-1:0]  prod_type;

   typedef coord_type [2:0] coord3_type;
   typedef ext_type   [2:0] ext3_type;
   typedef wide_type  [2:0] wide3_type;

   // difference of two coordinates, one bit wider
   function automatic ext_type sub_ext(input coord_type p, input coord_type r);
      return $signed({p[COORD_W-1], p}) - $signed({r[COORD_W-1], r});
   endfunction

   function automatic wide_type ext_to_wide(input ext_type e);
      return $signed({{(WIDE_W-EXT_W){e[EXT_W-1]}}, e});
   endfunction

   function automatic mulb_type ext_to_mulb(input ext_type e);
      return $signed({{(MUL_B_W-EXT_W){e[EXT_W-1]}}, e});
   endfunction

   function automatic mulb_type coord_to_mulb(input coord_type c);
      return $signed({{(MUL_B_W-COORD_W){c[COORD_W-1]}}, c});
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rti_mul.sv =====
// Two-stage signed multiplier, 102 by 34 bits, cut into three limb products.
// Depends on rti_pkg.
`default_nettype none

module rti_mul (
   input  logic              clock,
   input  logic              adv,
   input  rti_pkg::wide_type a,
   input  rti_pkg::mulb_type b,
   output rti_pkg::prod_type p
);

   localparam int LW = rti_pkg::LIMB_W;

   logic signed [2*LW:0]   pp0_in, pp0_ff, pp1_in, pp1_ff;
   logic signed [2*LW-1:0] pp2_in, pp2_ff;
   rti_pkg::prod_type      p_in, p_ff;

   // form limb products: two unsigned low limbs, signed top limb
   assign pp0_in = $signed({1'b0, a[LW-1:0]}) * b;
   assign pp1_in = $signed({1'b0, a[2*LW-1:LW]}) * b;
   assign pp2_in = $signed(a[3*LW-1:2*LW]) * b;

   always_ff @(posedge clock) begin
      if (adv) begin
         pp0_ff <= pp0_in;
         pp1_ff <= pp1_in;
         pp2_ff <= pp2_in;
      end
   end

   // align and add the limb products
   assign p_in = $signed({{(2*LW-1){pp0_ff[2*LW]}}, pp0_ff})
               + $signed({{(LW-1){pp1_ff[2*LW]}}, pp1_ff, {LW{1'b0}}})
               + $signed({pp2_ff, {(2*LW){1'b0}}});

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

// ===== rtl/rti_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, 34 stages.
// Depends on rti_pkg. Expects num below den shifted by the quotient width.
`default_nettype none

module rti_div (
   input  logic                              clock,
   input  logic                              adv,
   input  logic [rti_pkg::PROD_W-1:0]        num,
   input  logic [rti_pkg::WIDE_W-1:0]        den,
   output logic [rti_pkg::DIV_BITS-1:0]      quo
);

   localparam int NB = rti_pkg::DIV_BITS;
   localparam int RW = rti_pkg::PROD_W;
   localparam int DW = rti_pkg::WIDE_W;

   logic [RW-1:0] rem_ff [0:NB-2];
   logic [DW-1:0] den_ff [0:NB-2];
   logic [NB-1:0] quo_ff [0:NB-1];

   for (genvar j = 0; j < NB; j++) begin : g_stage
      logic [RW-1:0] rem_cur, sub_val, rem_in;
      logic [DW-1:0] den_cur;
      logic [NB-1:0] quo_cur, quo_in;
      logic          take;

      if (j == 0) begin : g_first
         assign rem_cur = num;
         assign den_cur = den;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[j-1];
         assign den_cur = den_ff[j-1];
         assign quo_cur = quo_ff[j-1];
      end

      // try to subtract the shifted divisor for this bit
      assign sub_val = {{(RW-DW){1'b0}}, den_cur} << (NB - 1 - j);
      assign take    = rem_cur >= sub_val;

      always_comb begin
         rem_in = take ? (rem_cur - sub_val) : rem_cur;
         quo_in = quo_cur;
         quo_in[NB-1-j] = take;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            quo_ff[j] <= quo_in;
         end
      end

      if (j < NB - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[j] <= rem_in;
               den_ff[j] <= den_cur;
            end
         end
      end
   end

   assign quo = quo_ff[NB-1];

endmodule

`default_nettype wire

// ===== rtl/ray_triangle_intersect.sv =====
// Top level of the fixed-point ray/triangle intersect pipeline.
// Depends on rti_pkg, rti_mul and rti_div.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | tdata: point x,y,z, dir x,y,z; tuser: op, vsel
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata: hit x,y,z, t, u, v; tuser: hit
//  csr     | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// One item enters per cycle while no result waits unaccepted; a test item passes
// through setup, two multiplier passes each followed by a sum stage, sign fix,
// a third multiplier pass, the dividend stage, the 34-stage divider and the
// output register before its rsp_tvalid rises.
// Reset clears the vertex store to zero and sets both registers to one.
// The whole pipeline holds while a result waits unaccepted; loads give no result.
`default_nettype none

module ray_triangle_intersect (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // point_x, point_y, point_z, dir_x, dir_y, dir_z (32 bits each)
   input  logic [rti_pkg::REQ_DATA_W-1:0]      req_tdata,
   // operation, vertex_select[1:0]
   input  logic [rti_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // hit_x, hit_y, hit_z (32), distance_t (31), bary_u (17), bary_v (17), zero fill
   output logic [rti_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // hit
   output logic [rti_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rti_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rti_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int CW = rti_pkg::COORD_W;
   localparam int WW = rti_pkg::WIDE_W;
   localparam int PW = rti_pkg::PROD_W;
   localparam int NB = rti_pkg::DIV_BITS;
   localparam int FB = rti_pkg::FRAC_BITS;

   typedef struct packed {
      rti_pkg::ext3_type   e1;
      rti_pkg::ext3_type   e2;
      rti_pkg::ext3_type   s;
      rti_pkg::coord3_type d;
      rti_pkg::coord3_type o;
   } side_b_type;

   typedef struct packed {
      rti_pkg::coord3_type d;
      rti_pkg::coord3_type o;
   } side_d_type;

   typedef struct packed {
      rti_pkg::wide_type   det;
      rti_pkg::wide_type   un;
      rti_pkg::wide_type   vn;
      rti_pkg::wide_type   tn;
      rti_pkg::coord3_type o;
      logic                prehit;
   } side_f_type;

   typedef struct packed {
      rti_pkg::coord3_type o;
      logic [2:0]          neg;
      logic [2:0]          ovf;
      logic                tov;
      logic                hit;
   } side_g_type;

   logic adv, in_acc;
   logic [rti_pkg::PIPE_DEPTH-1:0] vld_ff;

   logic [rti_pkg::CSR_DATA_W-1:0] det_eps_ff, t_min_ff;
   rti_pkg::coord3_type vert_ff [0:2];

   // ---------------- handshake ----------------
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign in_acc     = req_tvalid && adv;
   assign csr_ready  = 1'b1;

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[rti_pkg::PIPE_DEPTH-2:0],
                    in_acc && (req_tuser[0] == rti_pkg::OP_TEST)};
      end
   end

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         det_eps_ff <= 16'd1;
         t_min_ff   <= 16'd1;
      end else if (csr_valid) begin
         case (csr_index)
            rti_pkg::CSR_DET_EPS: det_eps_ff <= csr_data;
            rti_pkg::CSR_T_MIN:   t_min_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- vertex store ----------------
   rti_pkg::coord3_type in_pt, in_dir;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         in_pt[k]  = req_tdata[k*CW +: CW];
         in_dir[k] = req_tdata[(k+3)*CW +: CW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            vert_ff[k] <= '0;
         end
      end else if (in_acc && (req_tuser[0] == rti_pkg::OP_LOAD)) begin
         case (req_tuser[2:1])
            rti_pkg::VSEL_A: vert_ff[0] <= in_pt;
            rti_pkg::VSEL_B: vert_ff[1] <= in_pt;
            rti_pkg::VSEL_C: vert_ff[2] <= in_pt;
            default: ;
         endcase
      end
   end

   // ---------------- stage A: edges and origin offset ----------------
   side_b_type side_a_in, side_a_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         side_a_in.e1[k] = rti_pkg::sub_ext(vert_ff[1][k], vert_ff[0][k]);
         side_a_in.e2[k] = rti_pkg::sub_ext(vert_ff[2][k], vert_ff[0][k]);
         side_a_in.s[k]  = rti_pkg::sub_ext(in_pt[k], vert_ff[0][k]);
      end
      side_a_in.d = in_dir;
      side_a_in.o = in_pt;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_a_ff <= side_a_in;
      end
   end

   // ---------------- multiply B: cross products h and q ----------------
   rti_pkg::wide_type mb_a [0:11];
   rti_pkg::mulb_type mb_b [0:11];
   rti_pkg::prod_type mb_p [0:11];
   side_b_type        side_b_ff [0:1];

   always_comb begin
      mb_a[0]  = rti_pkg::ext_to_wide(side_a_ff.e2[2]);
      mb_b[0]  = rti_pkg::coord_to_mulb(side_a_ff.d[1]);
      mb_a[1]  = rti_pkg::ext_to_wide(side_a_ff.e2[1]);
      mb_b[1]  = rti_pkg::coord_to_mulb(side_a_ff.d[2]);
      mb_a[2]  = rti_pkg::ext_to_wide(side_a_ff.e2[0]);
      mb_b[2]  = rti_pkg::coord_to_mulb(side_a_ff.d[2]);
      mb_a[3]  = rti_pkg::ext_to_wide(side_a_ff.e2[2]);
      mb_b[3]  = rti_pkg::coord_to_mulb(side_a_ff.d[0]);
      mb_a[4]  = rti_pkg::ext_to_wide(side_a_ff.e2[1]);
      mb_b[4]  = rti_pkg::coord_to_mulb(side_a_ff.d[0]);
      mb_a[5]  = rti_pkg::ext_to_wide(side_a_ff.e2[0]);
      mb_b[5]  = rti_pkg::coord_to_mulb(side_a_ff.d[1]);
      mb_a[6]  = rti_pkg::ext_to_wide(side_a_ff.e1[2]);
      mb_b[6]  = rti_pkg::ext_to_mulb(side_a_ff.s[1]);
      mb_a[7]  = rti_pkg::ext_to_wide(side_a_ff.e1[1]);
      mb_b[7]  = rti_pkg::ext_to_mulb(side_a_ff.s[2]);
      mb_a[8]  = rti_pkg::ext_to_wide(side_a_ff.e1[0]);
      mb_b[8]  = rti_pkg::ext_to_mulb(side_a_ff.s[2]);
      mb_a[9]  = rti_pkg::ext_to_wide(side_a_ff.e1[2]);
      mb_b[9]  = rti_pkg::ext_to_mulb(side_a_ff.s[0]);
      mb_a[10] = rti_pkg::ext_to_wide(side_a_ff.e1[1]);
      mb_b[10] = rti_pkg::ext_to_mulb(side_a_ff.s[0]);
      mb_a[11] = rti_pkg::ext_to_wide(side_a_ff.e1[0]);
      mb_b[11] = rti_pkg::ext_to_mulb(side_a_ff.s[1]);
   end

   for (genvar k = 0; k < 12; k++) begin : g_mul_b
      rti_mul u_mul (.clock(clock), .adv(adv), .a(mb_a[k]), .b(mb_b[k]), .p(mb_p[k]));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_b_ff[0] <= side_a_ff;
         side_b_ff[1] <= side_b_ff[0];
      end
   end

   // ---------------- stage C: combine cross products ----------------
   rti_pkg::wide3_type h_in, h_ff, q_in, q_ff;
   side_b_type         side_c_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         h_in[k] = WW'(mb_p[2*k] - mb_p[2*k+1]);
         q_in[k] = WW'(mb_p[2*k+6] - mb_p[2*k+7]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_ff      <= h_in;
         q_ff      <= q_in;
         side_c_ff <= side_b_ff[1];
      end
   end

   // ---------------- multiply D: dot products ----------------
   rti_pkg::wide_type md_a [0:11];
   rti_pkg::mulb_type md_b [0:11];
   rti_pkg::prod_type md_p [0:11];
   side_d_type        side_d_ff [0:1];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         md_a[k]   = h_ff[k];
         md_b[k]   = rti_pkg::ext_to_mulb(side_c_ff.e1[k]);
         md_a[k+3] = h_ff[k];
         md_b[k+3] = rti_pkg::ext_to_mulb(side_c_ff.s[k]);
         md_a[k+6] = q_ff[k];
         md_b[k+6] = rti_pkg::coord_to_mulb(side_c_ff.d[k]);
         md_a[k+9] = q_ff[k];
         md_b[k+9] = rti_pkg::ext_to_mulb(side_c_ff.e2[k]);
      end
   end

   for (genvar k = 0; k < 12; k++) begin : g_mul_d
      rti_mul u_mul (.clock(clock), .adv(adv), .a(md_a[k]), .b(md_b[k]), .p(md_p[k]));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_d_ff[0] <= '{d: side_c_ff.d, o: side_c_ff.o};
         side_d_ff[1] <= side_d_ff[0];
      end
   end

   // ---------------- stage D: sum dot products ----------------
   rti_pkg::wide_type det_ff, un_ff, vn_ff, tn_ff;
   side_d_type        side_e_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         det_ff    <= WW'(md_p[0] + md_p[1] + md_p[2]);
         un_ff     <= WW'(md_p[3] + md_p[4] + md_p[5]);
         vn_ff     <= WW'(md_p[6] + md_p[7] + md_p[8]);
         tn_ff     <= WW'(md_p[9] + md_p[10] + md_p[11]);
         side_e_ff <= side_d_ff[1];
      end
   end

   // ---------------- stage E: sign fix and early tests ----------------
   rti_pkg::wide_type det_p, un_p, vn_p, tn_p;
   logic signed [WW:0] uv_sum;
   logic               eps_ok, u_ok, v_ok;
   side_f_type         side_fin, side_f0_ff;
   rti_pkg::coord3_type d_f_ff;

   always_comb begin
      det_p  = det_ff[WW-1] ? -det_ff : det_ff;
      un_p   = det_ff[WW-1] ? -un_ff  : un_ff;
      vn_p   = det_ff[WW-1] ? -vn_ff  : vn_ff;
      tn_p   = det_ff[WW-1] ? -tn_ff  : tn_ff;
      uv_sum = $signed({un_p[WW-1], un_p}) + $signed({vn_p[WW-1], vn_p});
      eps_ok = det_p > $signed({{(WW-16-2*FB){1'b0}}, det_eps_ff, {(2*FB){1'b0}}});
      u_ok   = !un_p[WW-1] && (un_p <= det_p);
      v_ok   = !vn_p[WW-1] && (uv_sum <= $signed({det_p[WW-1], det_p}));
      side_fin.det    = det_p;
      side_fin.un     = un_p;
      side_fin.vn     = vn_p;
      side_fin.tn     = tn_p;
      side_fin.o      = side_e_ff.o;
      side_fin.prehit = eps_ok && u_ok && v_ok;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_f0_ff <= side_fin;
         d_f_ff     <= side_e_ff.d;
      end
   end

   // ---------------- multiply F: t times direction, minimum t times det ----------------
   rti_pkg::wide_type mf_a [0:3];
   rti_pkg::mulb_type mf_b [0:3];
   rti_pkg::prod_type mf_p [0:3];
   side_f_type        side_f_ff [0:1];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mf_a[k] = side_f0_ff.tn;
         mf_b[k] = rti_pkg::coord_to_mulb(d_f_ff[k]);
      end
      mf_a[3] = side_f0_ff.det;
      mf_b[3] = $signed({{(rti_pkg::MUL_B_W-16){1'b0}}, t_min_ff});
   end

   for (genvar k = 0; k < 4; k++) begin : g_mul_f
      rti_mul u_mul (.clock(clock), .adv(adv), .a(mf_a[k]), .b(mf_b[k]), .p(mf_p[k]));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_f_ff[0] <= side_f0_ff;
         side_f_ff[1] <= side_f_ff[0];
      end
   end

   // ---------------- stage G: dividends, t test, overflow checks ----------------
   side_f_type        sf;
   rti_pkg::prod_type t_num;
   logic [PW-1:0]     num_in [0:5];
   logic [PW-1:0]     den_sh_coord, den_sh_t;
   side_g_type        side_gin;
   logic [PW-1:0]     num_g_ff [0:5];
   logic [WW-1:0]     den_g_ff;
   side_g_type        side_g_ff;

   always_comb begin
      sf           = side_f_ff[1];
      t_num        = $signed({{(PW-WW-FB){sf.tn[WW-1]}}, sf.tn, {FB{1'b0}}});
      den_sh_coord = {sf.det, {(PW-WW){1'b0}}};
      den_sh_t     = {{(PW-WW-CW+1){1'b0}}, sf.det, {(CW-1){1'b0}}};
      for (int k = 0; k < 3; k++) begin
         side_gin.neg[k] = mf_p[k][PW-1];
         num_in[k]       = mf_p[k][PW-1] ? PW'(-mf_p[k]) : PW'(mf_p[k]);
         side_gin.ovf[k] = num_in[k] >= den_sh_coord;
      end
      num_in[3]    = t_num;
      num_in[4]    = {{(PW-WW-FB){sf.un[WW-1]}}, sf.un, {FB{1'b0}}};
      num_in[5]    = {{(PW-WW-FB){sf.vn[WW-1]}}, sf.vn, {FB{1'b0}}};
      side_gin.tov = num_in[3] >= den_sh_t;
      side_gin.hit = sf.prehit && (mf_p[3] < t_num);
      side_gin.o   = sf.o;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 6; k++) begin
            num_g_ff[k] <= num_in[k];
         end
         den_g_ff  <= sf.det;
         side_g_ff <= side_gin;
      end
   end

   // ---------------- dividers ----------------
   logic [NB-1:0] quo [0:5];
   side_g_type    side_h_ff [0:NB-1];

   for (genvar k = 0; k < 6; k++) begin : g_div
      rti_div u_div (.clock(clock), .adv(adv), .num(num_g_ff[k]), .den(den_g_ff),
                     .quo(quo[k]));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_h_ff[0] <= side_g_ff;
         for (int k = 1; k < NB; k++) begin
            side_h_ff[k] <= side_h_ff[k-1];
         end
      end
   end

   // ---------------- stage H: saturate and pack ----------------
   side_g_type                      sh;
   logic signed [CW+3:0]            q_ext, p_sum;
   logic [CW-1:0]                   pt_out [0:2];
   logic [rti_pkg::T_W-1:0]         t_out;
   logic [rti_pkg::RSP_DATA_W-1:0]  data_in, data_ff;
   logic                            rsp_valid_ff, hit_ff;

   always_comb begin
      sh = side_h_ff[NB-1];
      for (int k = 0; k < 3; k++) begin
         q_ext = sh.neg[k] ? -$signed({2'b00, quo[k]}) : $signed({2'b00, quo[k]});
         p_sum = $signed({{4{sh.o[k][CW-1]}}, sh.o[k]}) + q_ext;
         if (sh.ovf[k]) begin
            pt_out[k] = sh.neg[k] ? rti_pkg::COORD_MIN : rti_pkg::COORD_MAX;
         end else if ((p_sum[CW+3:CW-1] == '0) || (p_sum[CW+3:CW-1] == '1)) begin
            pt_out[k] = p_sum[CW-1:0];
         end else begin
            pt_out[k] = p_sum[CW+3] ? rti_pkg::COORD_MIN : rti_pkg::COORD_MAX;
         end
      end
      t_out = sh.tov ? {rti_pkg::T_W{1'b1}} : quo[3][rti_pkg::T_W-1:0];
      data_in = '0;
      if (sh.hit) begin
         data_in = {{(rti_pkg::RSP_DATA_W - 3*CW - rti_pkg::T_W - 2*rti_pkg::BARY_W){1'b0}},
                    quo[5][rti_pkg::BARY_W-1:0], quo[4][rti_pkg::BARY_W-1:0], t_out,
                    pt_out[2], pt_out[1], pt_out[0]};
      end
   end

   // hold result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[rti_pkg::PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
         hit_ff  <= sh.hit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = hit_ff;

endmodule

`default_nettype wire

// ===== rtl/rti_chk.sv =====
// Port-level checker for the ray/triangle intersect block, bound to the top.
// Depends on rti_pkg and ray_triangle_intersect_macros.svh.
`default_nettype none
`include "ray_triangle_intersect_macros.svh"

module rti_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [rti_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input logic [rti_pkg::RSP_USER_W-1:0]      rsp_tuser
);

   logic [17:0] uv_sum;

   assign uv_sum = {1'b0, rsp_tdata[143:127]} + {1'b0, rsp_tdata[160:144]};

   // no result straight out of reset
   `RTI_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid, "result valid after reset")

   // a miss carries an all-zero payload
   `RTI_ASSERT(a_miss_zero, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0, "miss payload not zero")

   // barycentrics of a hit stay inside the triangle
   `RTI_ASSERT(a_bary_sum, rsp_tvalid && rsp_tuser[0] |-> uv_sum <= 18'd65536, "u plus v above one")

   // input side is open whenever no result waits
   `RTI_ASSERT(a_ready_open, !rsp_tvalid |-> req_tready, "input stalled with empty output")

   // a stalled result holds
   `RTI_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

endmodule

bind ray_triangle_intersect rti_chk u_rti_chk (.*);

`default_nettype wire
